>>> sv/integer_execute_branch_unit_assert.svh
// Assertion macros for the integer execute and branch unit.
// Included by the top level, the only RTL file that carries concurrent checks; no other dependencies.
`ifndef INTEGER_EXECUTE_BRANCH_UNIT_ASSERT_SVH
`define INTEGER_EXECUTE_BRANCH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check sampled on the rising clock, ignored while reset is low.
`define IEB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("integer_execute_branch_unit assertion failed");

// Check sampled on the rising clock, also during reset.
`define IEB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("integer_execute_branch_unit assertion failed");

`else

`define IEB_ASSERT(lbl, clk, rst_n, prop)
`define IEB_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> sv/ieb_pkg.sv
// Shared types and constants of the integer execute and branch unit.
// No dependencies; used by ieb_alu and the top level.
`default_nettype none

package ieb_pkg;

  localparam int DEFAULT_PC_BITS      = 16;
  localparam int DEFAULT_ADDRESS_BITS = 20;
  localparam int DATA_W               = 32;
  localparam int IMM_W                = 16;
  localparam int CMD_W                = 6;

  // Opcodes, densely numbered. Codes above the last branch act as halt.
  typedef enum logic [CMD_W-1:0] {
    CMD_NOP    = 6'd0,  CMD_HALT  = 6'd1,  CMD_ADD   = 6'd2,  CMD_SUB    = 6'd3,
    CMD_ADDI   = 6'd4,  CMD_SUBI  = 6'd5,  CMD_AND   = 6'd6,  CMD_OR     = 6'd7,
    CMD_NOR    = 6'd8,  CMD_XOR   = 6'd9,  CMD_ANDI  = 6'd10, CMD_ORI    = 6'd11,
    CMD_SLL    = 6'd12, CMD_SRL   = 6'd13, CMD_SRA   = 6'd14, CMD_MOV    = 6'd15,
    CMD_FMOV   = 6'd16, CMD_FABS  = 6'd17, CMD_FNEG  = 6'd18, CMD_LUI    = 6'd19,
    CMD_LLI    = 6'd20, CMD_FLUI  = 6'd21, CMD_FLLI  = 6'd22, CMD_LW     = 6'd23,
    CMD_LWI    = 6'd24, CMD_SW    = 6'd25, CMD_SWI   = 6'd26, CMD_FLW    = 6'd27,
    CMD_FLWA   = 6'd28, CMD_FLWN  = 6'd29, CMD_FLWI  = 6'd30, CMD_FLWIA  = 6'd31,
    CMD_FLWIN  = 6'd32, CMD_J     = 6'd33, CMD_JL    = 6'd34, CMD_JR     = 6'd35,
    CMD_JLR    = 6'd36,
    CMD_BEQ    = 6'd37, CMD_BNE   = 6'd38, CMD_BLTE  = 6'd39, CMD_BGTE   = 6'd40,
    CMD_FBEQ   = 6'd41, CMD_FBNE  = 6'd42, CMD_FBLTE = 6'd43, CMD_FBGTE  = 6'd44,
    CMD_BEQI   = 6'd45, CMD_BNEI  = 6'd46, CMD_BLTEI = 6'd47, CMD_BGTEI  = 6'd48,
    CMD_BEQR   = 6'd49, CMD_BNER  = 6'd50, CMD_BLTER = 6'd51, CMD_BGTER  = 6'd52,
    CMD_FBEQR  = 6'd53, CMD_FBNER = 6'd54, CMD_FBLTER = 6'd55, CMD_FBGTER = 6'd56,
    CMD_BEQIR  = 6'd57, CMD_BNEIR = 6'd58, CMD_BLTEIR = 6'd59, CMD_BGTEIR = 6'd60
  } cmd_e;

  typedef enum logic [1:0] {
    WT_NONE  = 2'd0,
    WT_INT   = 2'd1,
    WT_FLOAT = 2'd2,
    WT_LINK  = 2'd3
  } wtgt_e;

  typedef enum logic [1:0] {
    MOP_NONE  = 2'd0,
    MOP_LOAD  = 2'd1,
    MOP_STORE = 2'd2
  } mem_op_e;

  typedef enum logic [1:0] {
    LMOD_PLAIN = 2'd0,
    LMOD_ABS   = 2'd1,
    LMOD_NEG   = 2'd2
  } load_mod_e;

  // Control and status of one executed instruction.
  typedef struct packed {
    wtgt_e     write_target;
    logic      branch_taken;
    mem_op_e   memory_op;
    load_mod_e load_modifier;
    logic      address_error;
    logic      halt_request;
  } ieb_ctrl_t;

endpackage

`default_nettype wire

>>> sv/ieb_alu.sv
// Combinational execute logic: ALU, shifter, branch compares, address check.
// Depends on ieb_pkg.
`default_nettype none

module ieb_alu
  import ieb_pkg::*;
#(
  parameter int PC_BITS      = DEFAULT_PC_BITS,
  parameter int ADDRESS_BITS = DEFAULT_ADDRESS_BITS
) (
  input  logic [CMD_W-1:0]        command_i,
  input  logic [DATA_W-1:0]       rd_value_i,
  input  logic [DATA_W-1:0]       rs_value_i,
  input  logic [DATA_W-1:0]       rt_value_i,
  input  logic signed [IMM_W-1:0] immediate_i,
  input  logic signed [IMM_W-1:0] compare_immediate_i,
  input  logic [PC_BITS-1:0]      current_pc_i,
  output logic [DATA_W-1:0]       write_value_o,
  output logic [PC_BITS-1:0]      next_pc_o,
  output logic [ADDRESS_BITS-1:0] memory_address_o,
  output logic [DATA_W-1:0]       store_data_o,
  output ieb_ctrl_t               ctrl_o
);

  localparam logic [DATA_W-1:0] SIGN_MASK = {1'b1, {(DATA_W-1){1'b0}}};

  function automatic logic is_nan(input logic [DATA_W-1:0] a);
    return (&a[30:23]) && (|a[22:0]);
  endfunction

  function automatic logic f_eq(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] ab;
    ab = a | b;
    if (is_nan(a) || is_nan(b)) return 1'b0;
    return (ab[30:0] == '0) || (a == b);
  endfunction

  function automatic logic f_le(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] ab, ka, kb;
    ab = a | b;
    ka = a[31] ? ~a : (a | SIGN_MASK);
    kb = b[31] ? ~b : (b | SIGN_MASK);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    return (ab[30:0] == '0) || (ka <= kb);
  endfunction

  cmd_e              cmd;
  logic [DATA_W-1:0] imm32, amt32, cimm32, pc32;
  logic [DATA_W-1:0] sum_rt, sum_imm, addr;
  logic [DATA_W-1:0] pc_rel;
  logic              big_shift;
  logic              is_mem, reg_target, cond;

  // Compare results, one per branch family.
  logic i_eq, i_le, i_ge, f_eq_rs, f_le_rs, f_ge_rs, c_eq, c_le, c_ge;

  assign cmd       = cmd_e'(command_i);
  assign imm32     = {{(DATA_W-IMM_W){immediate_i[IMM_W-1]}}, immediate_i};
  assign amt32     = {{(DATA_W-IMM_W){1'b0}}, immediate_i};
  assign cimm32    = {{(DATA_W-IMM_W){compare_immediate_i[IMM_W-1]}}, compare_immediate_i};
  assign pc32      = DATA_W'(current_pc_i);
  assign sum_rt    = rs_value_i + rt_value_i;
  assign sum_imm   = rs_value_i + imm32;
  assign pc_rel    = pc32 + imm32;
  assign big_shift = |immediate_i[IMM_W-1:5];

  assign i_eq    = rd_value_i == rs_value_i;
  assign i_le    = $signed(rd_value_i) <= $signed(rs_value_i);
  assign i_ge    = $signed(rs_value_i) <= $signed(rd_value_i);
  assign f_eq_rs = f_eq(rd_value_i, rs_value_i);
  assign f_le_rs = f_le(rd_value_i, rs_value_i);
  assign f_ge_rs = f_le(rs_value_i, rd_value_i);
  assign c_eq    = rd_value_i == cimm32;
  assign c_le    = $signed(rd_value_i) <= $signed(cimm32);
  assign c_ge    = $signed(cimm32) <= $signed(rd_value_i);

  assign reg_target = command_i >= CMD_BEQR;

  always_comb begin
    write_value_o        = '0;
    next_pc_o            = current_pc_i;
    store_data_o         = '0;
    addr                 = '0;
    is_mem               = 1'b0;
    cond                 = 1'b0;
    ctrl_o.write_target  = WT_NONE;
    ctrl_o.branch_taken  = 1'b0;
    ctrl_o.memory_op     = MOP_NONE;
    ctrl_o.load_modifier = LMOD_PLAIN;
    ctrl_o.address_error = 1'b0;
    ctrl_o.halt_request  = 1'b0;

    unique case (cmd)
      CMD_NOP: ;
      CMD_ADD:  begin write_value_o = sum_rt;                      ctrl_o.write_target = WT_INT; end
      CMD_SUB:  begin write_value_o = rs_value_i - rt_value_i;     ctrl_o.write_target = WT_INT; end
      CMD_ADDI: begin write_value_o = sum_imm;                     ctrl_o.write_target = WT_INT; end
      CMD_SUBI: begin write_value_o = rs_value_i - imm32;          ctrl_o.write_target = WT_INT; end
      CMD_AND:  begin write_value_o = rs_value_i & rt_value_i;     ctrl_o.write_target = WT_INT; end
      CMD_OR:   begin write_value_o = rs_value_i | rt_value_i;     ctrl_o.write_target = WT_INT; end
      CMD_NOR:  begin write_value_o = ~(rs_value_i | rt_value_i);  ctrl_o.write_target = WT_INT; end
      CMD_XOR:  begin write_value_o = rs_value_i ^ rt_value_i;     ctrl_o.write_target = WT_INT; end
      CMD_ANDI: begin write_value_o = rs_value_i & imm32;          ctrl_o.write_target = WT_INT; end
      CMD_ORI:  begin write_value_o = rs_value_i | imm32;          ctrl_o.write_target = WT_INT; end
      CMD_SLL: begin
        write_value_o       = big_shift ? '0 : (rs_value_i << immediate_i[4:0]);
        ctrl_o.write_target = WT_INT;
      end
      CMD_SRL: begin
        write_value_o       = big_shift ? '0 : (rs_value_i >> immediate_i[4:0]);
        ctrl_o.write_target = WT_INT;
      end
      CMD_SRA: begin
        write_value_o       = big_shift ? {DATA_W{rs_value_i[DATA_W-1]}}
                                        : DATA_W'($signed(rs_value_i) >>> immediate_i[4:0]);
        ctrl_o.write_target = WT_INT;
      end
      CMD_MOV:  begin write_value_o = rs_value_i;              ctrl_o.write_target = WT_INT;   end
      CMD_FMOV: begin write_value_o = rs_value_i;              ctrl_o.write_target = WT_FLOAT; end
      CMD_FABS: begin write_value_o = rs_value_i & ~SIGN_MASK; ctrl_o.write_target = WT_FLOAT; end
      CMD_FNEG: begin write_value_o = rs_value_i ^ SIGN_MASK;  ctrl_o.write_target = WT_FLOAT; end
      CMD_LUI: begin
        write_value_o       = {amt32[15:0], rs_value_i[15:0]};
        ctrl_o.write_target = WT_INT;
      end
      CMD_LLI: begin
        write_value_o       = {rs_value_i[31:16], amt32[15:0]};
        ctrl_o.write_target = WT_INT;
      end
      CMD_FLUI: begin
        write_value_o       = {amt32[15:0], rs_value_i[15:0]};
        ctrl_o.write_target = WT_FLOAT;
      end
      CMD_FLLI: begin
        write_value_o       = {rs_value_i[31:16], amt32[15:0]};
        ctrl_o.write_target = WT_FLOAT;
      end
      CMD_LW: begin
        addr = sum_rt; is_mem = 1'b1;
        ctrl_o.memory_op = MOP_LOAD; ctrl_o.write_target = WT_INT;
      end
      CMD_LWI: begin
        addr = sum_imm; is_mem = 1'b1;
        ctrl_o.memory_op = MOP_LOAD; ctrl_o.write_target = WT_INT;
      end
      CMD_SW: begin
        addr = sum_rt; is_mem = 1'b1;
        ctrl_o.memory_op = MOP_STORE; store_data_o = rd_value_i;
      end
      CMD_SWI: begin
        addr = sum_imm; is_mem = 1'b1;
        ctrl_o.memory_op = MOP_STORE; store_data_o = rd_value_i;
      end
      CMD_FLW, CMD_FLWA, CMD_FLWN: begin
        addr = sum_rt; is_mem = 1'b1;
        ctrl_o.memory_op = MOP_LOAD; ctrl_o.write_target = WT_FLOAT;
        ctrl_o.load_modifier = (cmd == CMD_FLWA) ? LMOD_ABS :
                               (cmd == CMD_FLWN) ? LMOD_NEG : LMOD_PLAIN;
      end
      CMD_FLWI, CMD_FLWIA, CMD_FLWIN: begin
        addr = sum_imm; is_mem = 1'b1;
        ctrl_o.memory_op = MOP_LOAD; ctrl_o.write_target = WT_FLOAT;
        ctrl_o.load_modifier = (cmd == CMD_FLWIA) ? LMOD_ABS :
                               (cmd == CMD_FLWIN) ? LMOD_NEG : LMOD_PLAIN;
      end
      CMD_J:   next_pc_o = imm32[PC_BITS-1:0];
      CMD_JL: begin
        write_value_o = pc32; ctrl_o.write_target = WT_LINK;
        next_pc_o     = imm32[PC_BITS-1:0];
      end
      CMD_JR:  next_pc_o = rd_value_i[PC_BITS-1:0];
      CMD_JLR: begin
        write_value_o = pc32; ctrl_o.write_target = WT_LINK;
        next_pc_o     = rd_value_i[PC_BITS-1:0];
      end
      CMD_BEQ,   CMD_BEQR:   cond = i_eq;
      CMD_BNE,   CMD_BNER:   cond = !i_eq;
      CMD_BLTE,  CMD_BLTER:  cond = i_le;
      CMD_BGTE,  CMD_BGTER:  cond = i_ge;
      CMD_FBEQ,  CMD_FBEQR:  cond = f_eq_rs;
      CMD_FBNE,  CMD_FBNER:  cond = !f_eq_rs;
      CMD_FBLTE, CMD_FBLTER: cond = f_le_rs;
      CMD_FBGTE, CMD_FBGTER: cond = f_ge_rs;
      CMD_BEQI,  CMD_BEQIR:  cond = c_eq;
      CMD_BNEI,  CMD_BNEIR:  cond = !c_eq;
      CMD_BLTEI, CMD_BLTEIR: cond = c_le;
      CMD_BGTEI, CMD_BGTEIR: cond = c_ge;
      // halt and the unused codes
      default: ctrl_o.halt_request = 1'b1;
    endcase

    if (cond) begin
      ctrl_o.branch_taken = 1'b1;
      next_pc_o = reg_target ? rt_value_i[PC_BITS-1:0] : pc_rel[PC_BITS-1:0];
    end

    if (is_mem) begin
      memory_address_o = addr[ADDRESS_BITS-1:0];
      // wrapped sum must fit the address space
      if ((addr >> ADDRESS_BITS) != '0) begin
        ctrl_o.address_error = 1'b1;
        ctrl_o.memory_op     = MOP_NONE;
        ctrl_o.write_target  = WT_NONE;
        ctrl_o.load_modifier = LMOD_PLAIN;
        store_data_o         = '0;
      end
    end else begin
      memory_address_o = '0;
    end
  end

endmodule

`default_nettype wire

>>> sv/integer_execute_branch_unit.sv
// Top level of the integer execute and branch unit: input register, execute
// logic (ieb_alu), result register. Depends on ieb_pkg and the assertion header.
`default_nettype none
//
//  channel  | dir | fields (tdata, lowest bit first)
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | command, rd_value, rs_value, rt_value, immediate,
//           |     | compare_immediate, current_pc
//  m_axis   | out | write_value, write_target, next_pc, branch_taken, memory_op,
//           |     | memory_address, store_data, load_modifier, address_error,
//           |     | halt_request
//
//  One request per cycle sustained while m_axis does not stall. An accepted
//  request passes two register stages around one execute pass: it is held in
//  the input register, then captured in the result register (m_axis_tvalid).
//  Reset (rst_ni low, asynchronous) empties both stages; data regs keep junk.
//  A stalled result register holds; the input stage still fills behind it,
//  so s_axis_tready only drops when both stages are full and m_axis stalls.

`include "integer_execute_branch_unit_assert.svh"

module integer_execute_branch_unit
  import ieb_pkg::*;
#(
  parameter int PC_BITS      = DEFAULT_PC_BITS,
  parameter int ADDRESS_BITS = DEFAULT_ADDRESS_BITS,
  localparam int IN_BITS     = CMD_W + 3 * DATA_W + 2 * IMM_W + PC_BITS,
  localparam int IN_W        = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS    = 2 * DATA_W + PC_BITS + ADDRESS_BITS + 9,
  localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // command, rd_value, rs_value, rt_value, immediate, compare_immediate,
  // current_pc, zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // write_value, write_target, next_pc, branch_taken, memory_op,
  // memory_address, store_data, load_modifier, address_error, halt_request,
  // zero pad
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam int RD_LSB   = CMD_W;
  localparam int RS_LSB   = RD_LSB + DATA_W;
  localparam int RT_LSB   = RS_LSB + DATA_W;
  localparam int IMM_LSB  = RT_LSB + DATA_W;
  localparam int CIMM_LSB = IMM_LSB + IMM_W;
  localparam int PC_LSB   = CIMM_LSB + IMM_W;

  // ---- input stage ----
  logic                        in_valid_q, in_valid_d;
  logic [CMD_W-1:0]            command_q;
  logic [DATA_W-1:0]           rd_value_q, rs_value_q, rt_value_q;
  logic signed [IMM_W-1:0]     immediate_q, compare_immediate_q;
  logic [PC_BITS-1:0]          current_pc_q;

  // ---- result stage ----
  logic                        out_valid_q, out_valid_d;
  logic [DATA_W-1:0]           write_value_q, store_data_q;
  logic [PC_BITS-1:0]          next_pc_q;
  logic [ADDRESS_BITS-1:0]     memory_address_q;
  ieb_ctrl_t                   ctrl_q;

  // ---- execute results ----
  logic [DATA_W-1:0]           write_value_d, store_data_d;
  logic [PC_BITS-1:0]          next_pc_d;
  logic [ADDRESS_BITS-1:0]     memory_address_d;
  ieb_ctrl_t                   ctrl_d;

  logic out_adv, in_adv, in_fire;

  // Result register moves when empty or drained; input register when empty
  // or when its request moves on into the result register.
  assign out_adv       = !out_valid_q || m_axis_tready;
  assign in_adv        = !in_valid_q || out_adv;
  assign s_axis_tready = in_adv;
  assign in_fire       = s_axis_tvalid && in_adv;

  assign in_valid_d  = in_adv ? s_axis_tvalid : in_valid_q;
  assign out_valid_d = out_adv ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      command_q           <= s_axis_tdata[0 +: CMD_W];
      rd_value_q          <= s_axis_tdata[RD_LSB +: DATA_W];
      rs_value_q          <= s_axis_tdata[RS_LSB +: DATA_W];
      rt_value_q          <= s_axis_tdata[RT_LSB +: DATA_W];
      immediate_q         <= s_axis_tdata[IMM_LSB +: IMM_W];
      compare_immediate_q <= s_axis_tdata[CIMM_LSB +: IMM_W];
      current_pc_q        <= s_axis_tdata[PC_LSB +: PC_BITS];
    end
  end

  ieb_alu #(
    .PC_BITS      (PC_BITS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_alu (
    .command_i           (command_q),
    .rd_value_i          (rd_value_q),
    .rs_value_i          (rs_value_q),
    .rt_value_i          (rt_value_q),
    .immediate_i         (immediate_q),
    .compare_immediate_i (compare_immediate_q),
    .current_pc_i        (current_pc_q),
    .write_value_o       (write_value_d),
    .next_pc_o           (next_pc_d),
    .memory_address_o    (memory_address_d),
    .store_data_o        (store_data_d),
    .ctrl_o              (ctrl_d)
  );

  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      write_value_q    <= write_value_d;
      next_pc_q        <= next_pc_d;
      memory_address_q <= memory_address_d;
      store_data_q     <= store_data_d;
      ctrl_q           <= ctrl_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({ctrl_q.halt_request, ctrl_q.address_error,
                                 ctrl_q.load_modifier, store_data_q, memory_address_q,
                                 ctrl_q.memory_op, ctrl_q.branch_taken, next_pc_q,
                                 ctrl_q.write_target, write_value_q});

  // ---- checks ----
  // bad address must cancel the memory request and the register write
  `IEB_ASSERT(a_addr_err_cancels, clk_i, rst_ni,
    out_valid_q && ctrl_q.address_error |->
      ctrl_q.memory_op == MOP_NONE && ctrl_q.write_target == WT_NONE)
  // a taken branch is neither a halt nor a memory access
  `IEB_ASSERT(a_branch_clean, clk_i, rst_ni,
    out_valid_q && ctrl_q.branch_taken |->
      !ctrl_q.halt_request && ctrl_q.memory_op == MOP_NONE)
  // sign modifiers only ride on float loads
  `IEB_ASSERT(a_lmod_on_fload, clk_i, rst_ni,
    out_valid_q && ctrl_q.load_modifier != LMOD_PLAIN |->
      ctrl_q.memory_op == MOP_LOAD && ctrl_q.write_target == WT_FLOAT)
  // a full input stage that accepts must be handing its request on
  `IEB_ASSERT(a_no_overwrite, clk_i, rst_ni,
    in_fire && in_valid_q |-> out_adv)
  // both stages empty right after reset
  `IEB_ASSERT_ALWAYS(a_reset_empty, clk_i,
    !rst_ni |=> !in_valid_q && !out_valid_q)

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for integer_execute_branch_unit: a directed table, then
// random requests checked against an in-bench execute predictor. Depends on ieb_pkg.
`default_nettype none

module testbench;
  import ieb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W  = 152;
  localparam int OUT_W = 112;
  localparam int N_DIR = 25;
  localparam int RAND_PER_PHASE = 450;

  // Codes past the last branch decode as halt.
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 6'd63;

  // Branch block layout: 12 per target kind (pc+imm, then rt); within a block
  // 4 integer rd-vs-rs, 4 IEEE rd-vs-rs, 4 integer rd-vs-compare_immediate.
  localparam int BR_PER_TARGET  = 12;
  localparam int BR_FLOAT_FIRST = 4;
  localparam int BR_IMM_FIRST   = 8;
  localparam int BR_CONDS       = 4;

  typedef enum int {COND_EQ, COND_NE, COND_LE, COND_GE} cond_e;
  typedef enum int {PH_STEADY, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH} phase_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [31:0]      rd;
    logic [31:0]      rs;
    logic [31:0]      rt;
    logic [15:0]      imm;
    logic [15:0]      cimm;
    logic [15:0]      pc;
  } instr_t;

  typedef struct packed {
    logic [31:0] write_value;
    wtgt_e       write_target;
    logic [15:0] next_pc;
    logic        branch_taken;
    mem_op_e     memory_op;
    logic [19:0] memory_address;
    logic [31:0] store_data;
    load_mod_e   load_modifier;
    logic        address_error;
    logic        halt_request;
  } exec_res_t;

  typedef struct {
    instr_t    ins;
    bit        lit;   // 1: expected result typed in below, 0: predictor
    exec_res_t exp;
  } dir_row_t;

  localparam exec_res_t NO_LIT = '0;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  exec_res_t pending_results [$];
  int        mismatches = 0;
  phase_e    idle_mode  = PH_STEADY;

  integer_execute_branch_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Directed table: extremes, zero signs, NaN compares, address range edges,
  // PC wrap, unused codes.
  dir_row_t directed_tbl [N_DIR] = '{
    // first request after reset: all zero
    '{'{CMD_NOP, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
      '{32'h0, WT_NONE, 16'h0, 1'b0, MOP_NONE, 20'h0, 32'h0, LMOD_PLAIN, 1'b0, 1'b0}},
    '{'{CMD_HALT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
        16'h1234}, 1'b1,
      '{32'h0, WT_NONE, 16'h1234, 1'b0, MOP_NONE, 20'h0, 32'h0, LMOD_PLAIN, 1'b0, 1'b1}},
    '{'{CMD_UNUSED_LAST, 32'h1, 32'h2, 32'h3, 16'h4, 16'h5, 16'hFFFF}, 1'b1,
      '{32'h0, WT_NONE, 16'hFFFF, 1'b0, MOP_NONE, 20'h0, 32'h0, LMOD_PLAIN, 1'b0, 1'b1}},
    '{'{CMD_ADD, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'h0010}, 1'b1,
      '{32'hFFFF_FFFE, WT_INT, 16'h0010, 1'b0, MOP_NONE, 20'h0, 32'h0, LMOD_PLAIN,
        1'b0, 1'b0}},
    '{'{CMD_SUB, 32'h0, 32'h0, 32'h1, 16'h0, 16'h0, 16'h0}, 1'b1,
      '{32'hFFFF_FFFF, WT_INT, 16'h0, 1'b0, MOP_NONE, 20'h0, 32'h0, LMOD_PLAIN, 1'b0, 1'b0}},
    '{'{CMD_ADDI, 32'h0, 32'h0, 32'h0, 16'h8000, 16'h0, 16'h0}, 1'b1,
      '{32'hFFFF_8000, WT_INT, 16'h0, 1'b0, MOP_NONE, 20'h0, 32'h0, LMOD_PLAIN, 1'b0, 1'b0}},
    // shift by 32 clears
    '{'{CMD_SLL, 32'h0, 32'hFFFF_FFFF, 32'h0, 16'h0020, 16'h0, 16'h0}, 1'b1,
      '{32'h0, WT_INT, 16'h0, 1'b0, MOP_NONE, 20'h0, 32'h0, LMOD_PLAIN, 1'b0, 1'b0}},
    // huge arithmetic shift gives all sign bits
    '{'{CMD_SRA, 32'h0, 32'h8000_0000, 32'h0, 16'hFFFF, 16'h0, 16'h0}, 1'b1,
      '{32'hFFFF_FFFF, WT_INT, 16'h0, 1'b0, MOP_NONE, 20'h0, 32'h0, LMOD_PLAIN, 1'b0, 1'b0}},
    '{'{CMD_SRA, 32'h0, 32'h8000_0001, 32'h0, 16'h001F, 16'h0, 16'h0}, 1'b0, NO_LIT},
    '{'{CMD_FABS, 32'h0, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
      '{32'h7FFF_FFFF, WT_FLOAT, 16'h0, 1'b0, MOP_NONE, 20'h0, 32'h0, LMOD_PLAIN,
        1'b0, 1'b0}},
    '{'{CMD_FNEG, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
      '{32'h8000_0000, WT_FLOAT, 16'h0, 1'b0, MOP_NONE, 20'h0, 32'h0, LMOD_PLAIN,
        1'b0, 1'b0}},
    '{'{CMD_LUI, 32'h0, 32'h1234_5678, 32'h0, 16'hFFFF, 16'h0, 16'h0}, 1'b1,
      '{32'hFFFF_5678, WT_INT, 16'h0, 1'b0, MOP_NONE, 20'h0, 32'h0, LMOD_PLAIN, 1'b0, 1'b0}},
    // address sum wraps to zero: valid load
    '{'{CMD_LW, 32'h0, 32'hFFFF_FFFF, 32'h1, 16'h0, 16'h0, 16'h0}, 1'b1,
      '{32'h0, WT_INT, 16'h0, 1'b0, MOP_LOAD, 20'h0, 32'h0, LMOD_PLAIN, 1'b0, 1'b0}},
    // one past the top of memory
    '{'{CMD_LWI, 32'h0, 32'h000F_FFFF, 32'h0, 16'h0001, 16'h0, 16'h0}, 1'b1,
      '{32'h0, WT_NONE, 16'h0, 1'b0, MOP_NONE, 20'h0, 32'h0, LMOD_PLAIN, 1'b1, 1'b0}},
    // last word of memory
    '{'{CMD_SWI, 32'hDEAD_BEEF, 32'h000F_FFFF, 32'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
      '{32'h0, WT_NONE, 16'h0, 1'b0, MOP_STORE, 20'hF_FFFF, 32'hDEAD_BEEF, LMOD_PLAIN,
        1'b0, 1'b0}},
    '{'{CMD_FLWIN, 32'h0, 32'h0000_0100, 32'h0, 16'hFFFF, 16'h0, 16'h0}, 1'b0, NO_LIT},
    '{'{CMD_FLWA, 32'h0, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'h0}, 1'b0, NO_LIT},
    '{'{CMD_JL, 32'h0, 32'h0, 32'h0, 16'hFFFF, 16'h0, 16'h1234}, 1'b1,
      '{32'h1234, WT_LINK, 16'hFFFF, 1'b0, MOP_NONE, 20'h0, 32'h0, LMOD_PLAIN, 1'b0, 1'b0}},
    '{'{CMD_JLR, 32'hFFFF_ABCD, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0042}, 1'b1,
      '{32'h0042, WT_LINK, 16'hABCD, 1'b0, MOP_NONE, 20'h0, 32'h0, LMOD_PLAIN, 1'b0, 1'b0}},
    // +0 equals -0
    '{'{CMD_FBEQ, 32'h0, 32'h8000_0000, 32'h0, 16'h0010, 16'h0, 16'h0100}, 1'b0, NO_LIT},
    // NaN: not-equal holds, ordered compares fail
    '{'{CMD_FBNE, 32'h7FC0_0000, 32'h7FC0_0000, 32'h0, 16'h0010, 16'h0, 16'h0100},
      1'b0, NO_LIT},
    '{'{CMD_FBGTE, 32'h7F80_0001, 32'h0, 32'h0, 16'h0010, 16'h0, 16'h0100}, 1'b0, NO_LIT},
    '{'{CMD_BLTEI, 32'hFFFF_8000, 32'h0, 32'h0, 16'hFFF0, 16'h8000, 16'h0100}, 1'b0, NO_LIT},
    '{'{CMD_BGTER, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555, 16'h0, 16'h0, 16'h0100},
      1'b0, NO_LIT},
    // taken branch wraps the PC
    '{'{CMD_BEQ, 32'h5, 32'h5, 32'h0, 16'h0001, 16'h0, 16'hFFFF}, 1'b1,
      '{32'h0, WT_NONE, 16'h0, 1'b1, MOP_NONE, 20'h0, 32'h0, LMOD_PLAIN, 1'b0, 1'b0}}
  };

  // ---------------------------------------------------------------- predictor

  function automatic bit f_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != '0);
  endfunction

  function automatic bit f_eq(input logic [31:0] a, input logic [31:0] b);
    if (f_nan(a) || f_nan(b)) return 1'b0;
    if (((a | b) & 32'h7FFF_FFFF) == '0) return 1'b1;
    return a == b;
  endfunction

  // Maps IEEE bits onto an unsigned order.
  function automatic logic [31:0] f_key(input logic [31:0] a);
    return a[31] ? ~a : {1'b1, a[30:0]};
  endfunction

  function automatic bit f_le(input logic [31:0] a, input logic [31:0] b);
    if (f_nan(a) || f_nan(b)) return 1'b0;
    if (((a | b) & 32'h7FFF_FFFF) == '0) return 1'b1;
    return f_key(a) <= f_key(b);
  endfunction

  function automatic exec_res_t exec_predict(input instr_t ins);
    exec_res_t   r;
    logic [31:0] imm_x, cimm_x, ea, other;
    logic [15:0] amt;
    logic        mem, cond, is_f;
    int unsigned br, k;
    r       = '0;
    r.next_pc = ins.pc;
    imm_x   = {{16{ins.imm[15]}}, ins.imm};
    cimm_x  = {{16{ins.cimm[15]}}, ins.cimm};
    amt     = ins.imm;
    ea      = '0;
    mem     = 1'b0;
    cond    = 1'b0;
    case (ins.cmd)
      CMD_NOP: ;
      CMD_ADD:  begin r.write_value = ins.rs + ins.rt;    r.write_target = WT_INT; end
      CMD_SUB:  begin r.write_value = ins.rs - ins.rt;    r.write_target = WT_INT; end
      CMD_ADDI: begin r.write_value = ins.rs + imm_x;     r.write_target = WT_INT; end
      CMD_SUBI: begin r.write_value = ins.rs - imm_x;     r.write_target = WT_INT; end
      CMD_AND:  begin r.write_value = ins.rs & ins.rt;    r.write_target = WT_INT; end
      CMD_OR:   begin r.write_value = ins.rs | ins.rt;    r.write_target = WT_INT; end
      CMD_NOR:  begin r.write_value = ~(ins.rs | ins.rt); r.write_target = WT_INT; end
      CMD_XOR:  begin r.write_value = ins.rs ^ ins.rt;    r.write_target = WT_INT; end
      CMD_ANDI: begin r.write_value = ins.rs & imm_x;     r.write_target = WT_INT; end
      CMD_ORI:  begin r.write_value = ins.rs | imm_x;     r.write_target = WT_INT; end
      // shift amount is the raw 16-bit immediate
      CMD_SLL: begin
        r.write_value  = (amt >= 32) ? '0 : ins.rs << amt[4:0];
        r.write_target = WT_INT;
      end
      CMD_SRL: begin
        r.write_value  = (amt >= 32) ? '0 : ins.rs >> amt[4:0];
        r.write_target = WT_INT;
      end
      CMD_SRA: begin
        r.write_value  = (amt >= 32) ? {32{ins.rs[31]}} : 32'($signed(ins.rs) >>> amt[4:0]);
        r.write_target = WT_INT;
      end
      CMD_MOV:  begin r.write_value = ins.rs;                  r.write_target = WT_INT;   end
      CMD_FMOV: begin r.write_value = ins.rs;                  r.write_target = WT_FLOAT; end
      CMD_FABS: begin r.write_value = {1'b0, ins.rs[30:0]};    r.write_target = WT_FLOAT; end
      CMD_FNEG: begin r.write_value = {~ins.rs[31], ins.rs[30:0]}; r.write_target = WT_FLOAT; end
      CMD_LUI:  begin r.write_value = {amt, ins.rs[15:0]};     r.write_target = WT_INT;   end
      CMD_LLI:  begin r.write_value = {ins.rs[31:16], amt};    r.write_target = WT_INT;   end
      CMD_FLUI: begin r.write_value = {amt, ins.rs[15:0]};     r.write_target = WT_FLOAT; end
      CMD_FLLI: begin r.write_value = {ins.rs[31:16], amt};    r.write_target = WT_FLOAT; end
      CMD_LW: begin
        ea = ins.rs + ins.rt; mem = 1'b1; r.memory_op = MOP_LOAD; r.write_target = WT_INT;
      end
      CMD_LWI: begin
        ea = ins.rs + imm_x; mem = 1'b1; r.memory_op = MOP_LOAD; r.write_target = WT_INT;
      end
      CMD_SW: begin
        ea = ins.rs + ins.rt; mem = 1'b1; r.memory_op = MOP_STORE; r.store_data = ins.rd;
      end
      CMD_SWI: begin
        ea = ins.rs + imm_x; mem = 1'b1; r.memory_op = MOP_STORE; r.store_data = ins.rd;
      end
      CMD_FLW, CMD_FLWA, CMD_FLWN: begin
        ea = ins.rs + ins.rt; mem = 1'b1; r.memory_op = MOP_LOAD; r.write_target = WT_FLOAT;
        r.load_modifier = load_mod_e'(2'(ins.cmd - CMD_FLW));
      end
      CMD_FLWI, CMD_FLWIA, CMD_FLWIN: begin
        ea = ins.rs + imm_x; mem = 1'b1; r.memory_op = MOP_LOAD; r.write_target = WT_FLOAT;
        r.load_modifier = load_mod_e'(2'(ins.cmd - CMD_FLWI));
      end
      CMD_J:  r.next_pc = ins.imm;
      CMD_JL: begin
        r.write_value = {16'h0, ins.pc}; r.write_target = WT_LINK; r.next_pc = ins.imm;
      end
      CMD_JR: r.next_pc = ins.rd[15:0];
      CMD_JLR: begin
        r.write_value = {16'h0, ins.pc}; r.write_target = WT_LINK; r.next_pc = ins.rd[15:0];
      end
      default: begin
        if (ins.cmd >= CMD_BEQ && ins.cmd <= CMD_BGTEIR) begin
          br    = 32'(ins.cmd - CMD_BEQ);
          k     = br % BR_PER_TARGET;
          other = (k >= BR_IMM_FIRST) ? cimm_x : ins.rs;
          is_f  = (k >= BR_FLOAT_FIRST) && (k < BR_IMM_FIRST);
          case (cond_e'(k % BR_CONDS))
            COND_EQ: cond = is_f ? f_eq(ins.rd, other) : (ins.rd == other);
            COND_NE: cond = is_f ? !f_eq(ins.rd, other) : (ins.rd != other);
            COND_LE: cond = is_f ? f_le(ins.rd, other) : ($signed(ins.rd) <= $signed(other));
            default: cond = is_f ? f_le(other, ins.rd) : ($signed(other) <= $signed(ins.rd));
          endcase
          if (cond) begin
            r.branch_taken = 1'b1;
            r.next_pc      = (br >= BR_PER_TARGET) ? ins.rt[15:0] : ins.pc + ins.imm;
          end
        end else begin
          // halt and the unused codes
          r.halt_request = 1'b1;
        end
      end
    endcase
    if (mem) begin
      r.memory_address = ea[19:0];
      if ((ea >> DEFAULT_ADDRESS_BITS) != '0) begin
        // out of range: request dropped, no register write
        r.address_error = 1'b1;
        r.memory_op     = MOP_NONE;
        r.write_target  = WT_NONE;
        r.store_data    = '0;
        r.load_modifier = LMOD_PLAIN;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // Operand bits biased toward signs, IEEE specials and in-range addresses.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return {1'($urandom_range(0, 1)), 8'hFF,
                 ($urandom_range(0, 1) != 0) ? 23'($urandom) : 23'h0};
      5: return $urandom_range(0, 64);
      6: return $urandom_range(0, 20'hF_FFFF);
      default: return $urandom();
    endcase
  endfunction

  function automatic instr_t rand_instr();
    instr_t ins;
    ins.cmd = CMD_W'($urandom_range(0, 63));
    ins.rd  = pick_word();
    ins.rs  = pick_word();
    ins.rt  = pick_word();
    case ($urandom_range(0, 3))
      0: ins.imm = 16'($urandom_range(0, 40));
      1: ins.imm = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      default: ins.imm = 16'($urandom());
    endcase
    ins.cimm = 16'($urandom());
    ins.pc   = 16'($urandom());
    // steer branches toward equal operands so both outcomes show up
    if ($urandom_range(0, 3) == 0) ins.rs = ins.rd;
    if ($urandom_range(0, 5) == 0) ins.rd = {{16{ins.cimm[15]}}, ins.cimm};
    // keep most memory requests inside the address space
    if (ins.cmd >= CMD_LW && ins.cmd <= CMD_FLWIN && $urandom_range(0, 1) != 0) begin
      ins.rs = $urandom_range(0, 20'hF_FFFF);
      ins.rt = $urandom_range(0, 255);
    end
    return ins;
  endfunction

  function automatic bit idle_roll(input bit sink);
    case (idle_mode)
      PH_SRC_IDLE:   return !sink && ($urandom_range(0, 99) < 79);
      PH_SINK_STALL: return sink && ($urandom_range(0, 99) < 79);
      PH_BOTH:       return $urandom_range(0, 99) < 23;
      default:       return 1'b0;
    endcase
  endfunction

  // Drive one request; its expectation is queued at the accepting edge.
  task automatic send_request(input instr_t ins, input exec_res_t exp);
    while (idle_roll(1'b0)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, ins.pc, ins.cimm, ins.imm, ins.rt, ins.rs, ins.rd, ins.cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(exp);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    exec_res_t e;
    if (pending_results.size() == 0) begin
      $display("%0t: result with no request outstanding, actual %h", $time, m_axis_tdata);
      mismatches++;
    end else begin
      e = pending_results.pop_front();
      cmp_field("write_value",    e.write_value,         m_axis_tdata[31:0]);
      cmp_field("write_target",   32'(e.write_target),   32'(m_axis_tdata[33:32]));
      cmp_field("next_pc",        32'(e.next_pc),        32'(m_axis_tdata[49:34]));
      cmp_field("branch_taken",   32'(e.branch_taken),   32'(m_axis_tdata[50]));
      cmp_field("memory_op",      32'(e.memory_op),      32'(m_axis_tdata[52:51]));
      cmp_field("memory_address", 32'(e.memory_address), 32'(m_axis_tdata[72:53]));
      cmp_field("store_data",     e.store_data,          m_axis_tdata[104:73]);
      cmp_field("load_modifier",  32'(e.load_modifier),  32'(m_axis_tdata[106:105]));
      cmp_field("address_error",  32'(e.address_error),  32'(m_axis_tdata[107]));
      cmp_field("halt_request",   32'(e.halt_request),   32'(m_axis_tdata[108]));
    end
  endtask

  // ---------------------------------------------------------------- processes

  initial begin : clock_gen
    forever #4 clk_i = ~clk_i;
  end

  // Result side: handshake sampled at the edge, tready re-rolled every cycle.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
      m_axis_tready <= !idle_roll(1'b1);
    end
  end

  initial begin : run_limit
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    phase_e phase_order [4];
    instr_t ins;
    phase_order = '{PH_STEADY, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tbl[i]) begin
      send_request(directed_tbl[i].ins,
                   directed_tbl[i].lit ? directed_tbl[i].exp
                                       : exec_predict(directed_tbl[i].ins));
    end

    // every command code once, random operands
    for (int c = 0; c <= int'(CMD_UNUSED_LAST); c++) begin
      ins     = rand_instr();
      ins.cmd = CMD_W'(c);
      send_request(ins, exec_predict(ins));
    end

    foreach (phase_order[p]) begin
      idle_mode = phase_order[p];
      repeat (RAND_PER_PHASE) begin
        ins = rand_instr();
        send_request(ins, exec_predict(ins));
      end
    end

    s_axis_tvalid <= 1'b0;
    idle_mode = PH_STEADY;
    while (pending_results.size() != 0) @(posedge clk_i);
    // two-stage pipe: let any stray result surface
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
